// ===== sv/skit_pkg.sv =====
// ============================================================================
// skit_pkg: shared types and helpers of the sorted key index table
// Holds the item structs, the command and status codes and the key compare.
// ============================================================================
package skit_pkg;

   localparam int DEPTH       = 64;
   localparam int MAX_KEY_LEN = 8;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   localparam logic [2:0] CMD_INSERT   = 3'd0;
   localparam logic [2:0] CMD_FINALIZE = 3'd1;
   localparam logic [2:0] CMD_REMOVE   = 3'd2;
   localparam logic [2:0] CMD_LOOKUP   = 3'd3;
   localparam logic [2:0] CMD_RANGE    = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NONE     = 2'd2;
   localparam logic [1:0] ST_DISABLED = 2'd3;

   localparam logic [1:0] CMP_LT = 2'b11;
   localparam logic [1:0] CMP_EQ = 2'b00;
   localparam logic [1:0] CMP_GT = 2'b01;

   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] key_value;
      logic [3:0]  key_length;
      logic [63:0] upper_key_value;
      logic [3:0]  upper_key_length;
      logic [31:0] segment_number;
      logic [31:0] row_position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [63:0] found_key_value;
      logic [3:0]  found_key_length;
      logic [31:0] found_segment;
      logic [31:0] found_row;
      logic [6:0]  removed_count;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] seg;
      logic [31:0] row;
   } entry_type;

   function automatic logic [3:0] clamp_len(input logic [3:0] n);
      clamp_len = (n > 4'(MAX_KEY_LEN)) ? 4'(MAX_KEY_LEN) : n;
   endfunction

   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (b < int'(n)) m[63 - 8*b -: 8] = 8'hFF;
      end
      byte_mask = m;
   endfunction

   // below / equal / above coded as CMP_LT / CMP_EQ / CMP_GT
   function automatic logic [1:0] key_cmp(input logic [63:0] va, input logic [3:0] la,
                                          input logic [63:0] vb, input logic [3:0] lb);
      logic [63:0] m;
      m = byte_mask((la < lb) ? la : lb);
      if ((va & m) != (vb & m)) key_cmp = ((va & m) < (vb & m)) ? CMP_LT : CMP_GT;
      else if (la != lb)        key_cmp = (la < lb) ? CMP_LT : CMP_GT;
      else                      key_cmp = CMP_EQ;
   endfunction

endpackage

// ===== sv/sorted_key_index_table.sv =====
// Finalize, unknown codes, a full table or a disabled index are answered straight from
// idle; otherwise each entry visited is read, then compared and written back, and a range
// query adds an emit step for each match after the first, which waits out result stalls.
// Throughput: one item at a time, taken only while idle with no result pending;
// a range query emits one item per match, and each result waits while the result side stalls.
// Reset: synchronous, clears the entry count and enables the index; memory is not cleared.
// ============================================================================
// sorted_key_index_table: sorted key index with insert, remove, lookup, range
// One memory of entries, read-modify-write by a small sequencer.
// ============================================================================
module sorted_key_index_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  skit_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output skit_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);
   import skit_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_EMIT, S_DONE} state_type;

   state_type           state_ff;
   req_type             cmd_ff;
   logic                en_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    ptr_ff;      // read pointer
   logic [CNT_W-1:0]    wptr_ff;     // compaction write pointer
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic                have_ff;     // range: a pending match is held
   entry_type           held_ff;

   entry_type           mem [DEPTH];
   entry_type           rd_ff;
   logic                we;
   logic [IDX_W-1:0]    waddr;
   entry_type           wdata;
   logic [IDX_W-1:0]    raddr;

   entry_type           new_e;
   logic [1:0]          c_lo, c_hi;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      new_e.len = clamp_len(cmd_ff.key_length);
      new_e.key = cmd_ff.key_value & byte_mask(new_e.len);
      new_e.seg = cmd_ff.segment_number;
      new_e.row = cmd_ff.row_position;
      c_lo = key_cmp(rd_ff.key, rd_ff.len, new_e.key, new_e.len);
      c_hi = key_cmp(rd_ff.key, rd_ff.len,
                     cmd_ff.upper_key_value & byte_mask(clamp_len(cmd_ff.upper_key_length)),
                     clamp_len(cmd_ff.upper_key_length));
   end

   // Insert reads entry ptr-1; emit rereads the match just passed (ptr-1) so rd_ff
   // keeps it through a result stall; other commands read entry ptr.
   always_comb begin
      raddr = (cmd_ff.command == CMD_INSERT || state_ff == S_EMIT) ? IDX_W'(ptr_ff - 1'b1)
                                                                    : IDX_W'(ptr_ff);
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   function automatic rsp_type mk(input logic [1:0] st, input logic h, input entry_type e,
                                  input logic [6:0] rc, input logic lst);
      rsp_type r;
      r.status           = st;
      r.hit              = h;
      r.found_key_value  = h ? e.key : '0;
      r.found_key_length = h ? e.len : '0;
      r.found_segment    = h ? e.seg : '0;
      r.found_row        = h ? e.row : '0;
      r.removed_count    = rc;
      r.last_result      = lst;
      return r;
   endfunction

   always_comb begin
      we    = 1'b0;
      waddr = IDX_W'(ptr_ff);
      wdata = rd_ff;
      if (state_ff == S_EVAL) begin
         unique case (cmd_ff.command)
            CMD_INSERT: begin
               we = 1'b1;
               if (ptr_ff != '0 && c_lo == CMP_GT) begin
                  waddr = IDX_W'(ptr_ff);
                  wdata = rd_ff;
               end else begin
                  waddr = IDX_W'(ptr_ff);
                  wdata = new_e;
               end
            end
            CMD_REMOVE: begin
               // shift a kept entry down to the compaction point
               we    = (rd_ff.seg != cmd_ff.segment_number);
               waddr = IDX_W'(wptr_ff);
               wdata = rd_ff;
            end
            default: we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         en_ff        <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         ptr_ff       <= '0;
         wptr_ff      <= '0;
      end else begin
         if (csr_valid) en_ff <= csr_data;
         // emit and done states reload the result register themselves
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT && state_ff != S_DONE)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  cmd_ff  <= req_data;
                  have_ff <= 1'b0;
                  wptr_ff <= '0;
                  if (!en_ff) begin
                     rsp_ff <= mk(ST_DISABLED, 1'b0, rd_ff, '0, 1'b1);
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     case (req_data.command)
                        CMD_INSERT: begin
                           if (count_ff == CNT_W'(DEPTH)) begin
                              rsp_ff <= mk(ST_FULL, 1'b0, rd_ff, '0, 1'b1);
                              rsp_valid_ff <= 1'b1;
                           end else begin
                              ptr_ff   <= count_ff;
                              state_ff <= S_READ;
                           end
                        end
                        CMD_REMOVE, CMD_LOOKUP, CMD_RANGE: begin
                           ptr_ff   <= '0;
                           state_ff <= S_READ;
                        end
                        CMD_FINALIZE: begin
                           rsp_ff <= mk(ST_OK, 1'b0, rd_ff, '0, 1'b1);
                           rsp_valid_ff <= 1'b1;
                        end
                        default: begin
                           rsp_ff <= mk(ST_NONE, 1'b0, rd_ff, '0, 1'b1);
                           rsp_valid_ff <= 1'b1;
                        end
                     endcase
                  end
               end
            end
            S_READ: begin
               // memory read of raddr lands in rd_ff next cycle
               state_ff <= S_EVAL;
               if (cmd_ff.command != CMD_INSERT && ptr_ff == count_ff) state_ff <= S_DONE;
               if (cmd_ff.command == CMD_INSERT && ptr_ff == '0) state_ff <= S_EVAL;
            end
            S_EVAL: begin
               case (cmd_ff.command)
                  CMD_INSERT: begin
                     if (ptr_ff != '0 && c_lo == CMP_GT) begin
                        ptr_ff   <= ptr_ff - 1'b1;
                        state_ff <= S_READ;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                        state_ff <= S_DONE;
                     end
                  end
                  CMD_REMOVE: begin
                     if (rd_ff.seg != cmd_ff.segment_number) wptr_ff <= wptr_ff + 1'b1;
                     ptr_ff   <= ptr_ff + 1'b1;
                     state_ff <= S_READ;
                  end
                  CMD_LOOKUP: begin
                     if (c_lo == CMP_EQ) begin
                        rsp_ff <= mk(ST_OK, 1'b1, rd_ff, '0, 1'b1);
                        rsp_valid_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end else if (c_lo == CMP_GT) begin
                        ptr_ff   <= count_ff;
                        state_ff <= S_DONE;
                     end else begin
                        ptr_ff   <= ptr_ff + 1'b1;
                        state_ff <= S_READ;
                     end
                  end
                  default: begin
                     // range: match when key >= low and key <= high
                     if (c_lo != CMP_LT && c_hi != CMP_GT) begin
                        ptr_ff <= ptr_ff + 1'b1;
                        if (have_ff) begin
                           state_ff <= S_EMIT;
                        end else begin
                           held_ff  <= rd_ff;
                           have_ff  <= 1'b1;
                           state_ff <= S_READ;
                        end
                     end else if (c_hi == CMP_GT) begin
                        ptr_ff   <= count_ff;
                        state_ff <= S_DONE;
                     end else begin
                        ptr_ff   <= ptr_ff + 1'b1;
                        state_ff <= S_READ;
                     end
                  end
               endcase
            end
            S_EMIT: begin
               // emit the held match (not last), hold the new one
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= mk(ST_OK, 1'b1, held_ff, '0, 1'b0);
                  rsp_valid_ff <= 1'b1;
                  held_ff      <= rd_ff;
                  state_ff     <= S_READ;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  case (cmd_ff.command)
                     CMD_INSERT: rsp_ff <= mk(ST_OK, 1'b0, rd_ff, '0, 1'b1);
                     CMD_REMOVE: begin
                        rsp_ff   <= mk(ST_OK, 1'b0, rd_ff, 7'(count_ff - wptr_ff), 1'b1);
                        count_ff <= wptr_ff;
                     end
                     CMD_LOOKUP: rsp_ff <= mk(ST_NONE, 1'b0, rd_ff, '0, 1'b1);
                     default:
                        rsp_ff <= have_ff ? mk(ST_OK, 1'b1, held_ff, '0, 1'b1)
                                          : mk(ST_NONE, 1'b0, rd_ff, '0, 1'b1);
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("entry count above depth");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("item taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
`endif

endmodule

// ===== verif/sorted_key_index_table_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sorted_key_index_table_tb: self-checking bench of the sorted key index table
// Drives commands with random gaps, predicts every response from a local copy
// of the table, and compares each response field by field in order.
// ============================================================================
module sorted_key_index_table_tb;
   import skit_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   sorted_key_index_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Local copy of the table, kept sorted exactly as the block keeps it.
   logic [63:0] tbl_key [DEPTH];
   logic [3:0]  tbl_len [DEPTH];
   logic [31:0] tbl_seg [DEPTH];
   logic [31:0] tbl_row [DEPTH];
   int          tbl_count;
   logic        tbl_enabled;

   rsp_type pending_rsp[$];
   int      error_count;
   int      idle_cycles;
   logic    stall_quiet;   // when set, the response side never stalls

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Short gaps most of the time, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Signed order of two keys: shorter prefix sorts first.
   function automatic int order_keys(logic [63:0] va, logic [3:0] la,
                                     logic [63:0] vb, logic [3:0] lb);
      logic [3:0]  n;
      logic [63:0] m;
      n = (la < lb) ? la : lb;
      m = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
      if ((va & m) != (vb & m)) return ((va & m) < (vb & m)) ? -1 : 1;
      if (la != lb) return (la < lb) ? -1 : 1;
      return 0;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] st, int idx, logic [6:0] removed,
                                        logic last);
      rsp_type r;
      r = '0;
      r.status = st;
      r.removed_count = removed;
      r.last_result = last;
      if (idx >= 0) begin
         r.hit = 1'b1;
         r.found_key_value = tbl_key[idx];
         r.found_key_length = tbl_len[idx];
         r.found_segment = tbl_seg[idx];
         r.found_row = tbl_row[idx];
      end
      return r;
   endfunction

   // Append one predicted response at the tail of the queue.
   function automatic void queue_rsp(rsp_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // Apply one accepted command to the local table and queue its responses.
   task automatic predict_table(req_type q);
      logic [3:0]  klen, ulen;
      logic [63:0] kval, uval;
      int          i, k, lo, hi, c;
      klen = (q.key_length > MAX_KEY_LEN) ? 4'(MAX_KEY_LEN) : q.key_length;
      ulen = (q.upper_key_length > MAX_KEY_LEN) ? 4'(MAX_KEY_LEN) : q.upper_key_length;
      kval = q.key_value & ((klen == 0) ? 64'd0 : ~64'd0 << (64 - 8 * klen));
      uval = q.upper_key_value & ((ulen == 0) ? 64'd0 : ~64'd0 << (64 - 8 * ulen));
      if (!tbl_enabled) begin
         queue_rsp(make_rsp(ST_DISABLED, -1, '0, 1'b1));
         return;
      end
      case (q.command)
         CMD_INSERT: begin
            if (tbl_count >= DEPTH) begin
               queue_rsp(make_rsp(ST_FULL, -1, '0, 1'b1));
            end else begin
               i = tbl_count;
               while (i > 0 && order_keys(tbl_key[i-1], tbl_len[i-1], kval, klen) > 0) begin
                  tbl_key[i] = tbl_key[i-1];
                  tbl_len[i] = tbl_len[i-1];
                  tbl_seg[i] = tbl_seg[i-1];
                  tbl_row[i] = tbl_row[i-1];
                  i--;
               end
               tbl_key[i] = kval;
               tbl_len[i] = klen;
               tbl_seg[i] = q.segment_number;
               tbl_row[i] = q.row_position;
               tbl_count++;
               queue_rsp(make_rsp(ST_OK, -1, '0, 1'b1));
            end
         end
         CMD_FINALIZE: queue_rsp(make_rsp(ST_OK, -1, '0, 1'b1));
         CMD_REMOVE: begin
            k = 0;
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_seg[i] != q.segment_number) begin
                  tbl_key[k] = tbl_key[i];
                  tbl_len[k] = tbl_len[i];
                  tbl_seg[k] = tbl_seg[i];
                  tbl_row[k] = tbl_row[i];
                  k++;
               end
            end
            queue_rsp(make_rsp(ST_OK, -1, 7'(tbl_count - k), 1'b1));
            tbl_count = k;
         end
         CMD_LOOKUP: begin
            k = -1;
            for (i = 0; i < tbl_count; i++) begin
               c = order_keys(tbl_key[i], tbl_len[i], kval, klen);
               if (c == 0) begin
                  k = i;
                  break;
               end
               if (c > 0) break;
            end
            if (k >= 0) queue_rsp(make_rsp(ST_OK, k, '0, 1'b1));
            else queue_rsp(make_rsp(ST_NONE, -1, '0, 1'b1));
         end
         CMD_RANGE: begin
            lo = 0;
            hi = 0;
            while (lo < tbl_count && order_keys(tbl_key[lo], tbl_len[lo], kval, klen) < 0)
               lo++;
            while (hi < tbl_count && order_keys(tbl_key[hi], tbl_len[hi], uval, ulen) <= 0)
               hi++;
            if (hi <= lo) begin
               queue_rsp(make_rsp(ST_NONE, -1, '0, 1'b1));
            end else begin
               for (i = lo; i < hi; i++)
                  queue_rsp(make_rsp(ST_OK, i, '0, i == hi - 1));
            end
         end
         default: queue_rsp(make_rsp(ST_NONE, -1, '0, 1'b1));
      endcase
   endtask

   // Offer one item and hold it until the block takes it; drop valid only for a gap.
   task automatic send_item(req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_table(q);
   endtask

   // Wait until every queued response has come back, then let the block settle.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_enable(logic value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tbl_enabled = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random response-side stall, with quiet stretches.
   always @(posedge clock) begin
      if (reset || stall_quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 25);
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.found_key_value !== want.found_key_value) begin
               $error("found_key_value: expected %h actual %h",
                      want.found_key_value, rsp_data.found_key_value);
               error_count++;
            end
            if (rsp_data.found_key_length !== want.found_key_length) begin
               $error("found_key_length: expected %0d actual %0d",
                      want.found_key_length, rsp_data.found_key_length);
               error_count++;
            end
            if (rsp_data.found_segment !== want.found_segment) begin
               $error("found_segment: expected %h actual %h",
                      want.found_segment, rsp_data.found_segment);
               error_count++;
            end
            if (rsp_data.found_row !== want.found_row) begin
               $error("found_row: expected %h actual %h", want.found_row, rsp_data.found_row);
               error_count++;
            end
            if (rsp_data.removed_count !== want.removed_count) begin
               $error("removed_count: expected %0d actual %0d",
                      want.removed_count, rsp_data.removed_count);
               error_count++;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $error("last_result: expected %0d actual %0d",
                      want.last_result, rsp_data.last_result);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Keys drawn from a small alphabet so equal keys, prefixes and hits are common.
   function automatic req_type rand_item(logic [2:0] cmd);
      req_type q;
      q = '0;
      q.command = cmd;
      for (int b = 0; b < 8; b++) begin
         q.key_value[63 - 8*b -: 8] = 8'($urandom_range(0, 3)) << 6;
         q.upper_key_value[63 - 8*b -: 8] = 8'($urandom_range(0, 3)) << 6;
      end
      if ($urandom_range(0, 9) == 0) begin
         q.key_value = {$urandom, $urandom};
         q.upper_key_value = {$urandom, $urandom};
      end
      q.key_length = 4'($urandom_range(0, 15) < 12 ? $urandom_range(0, 3) : $urandom_range(0, 15));
      q.upper_key_length = 4'($urandom_range(0, 15));
      q.segment_number = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
      q.row_position = $urandom;
      return q;
   endfunction

   function automatic req_type key_item(logic [2:0] cmd, logic [63:0] k, logic [3:0] l);
      req_type q;
      q = '0;
      q.command = cmd;
      q.key_value = k;
      q.key_length = l;
      return q;
   endfunction

   // Corners: empty keys, long lengths, extreme fields, all commands.
   task automatic test_directed();
      req_type q;
      send_item(key_item(CMD_LOOKUP, 64'd0, 4'd0));
      send_item(key_item(CMD_RANGE, 64'd0, 4'd0));
      q = key_item(CMD_INSERT, ~64'd0, 4'd15);
      q.segment_number = '1;
      q.row_position = '1;
      send_item(q);
      send_item(key_item(CMD_INSERT, 64'h4100_0000_0000_0000, 4'd1));
      send_item(key_item(CMD_INSERT, 64'h4142_FFFF_FFFF_FFFF, 4'd2));
      send_item(key_item(CMD_INSERT, 64'h4100_0000_0000_0000, 4'd1));
      send_item(key_item(CMD_INSERT, 64'd0, 4'd0));
      send_item(key_item(CMD_LOOKUP, 64'h41FF_0000_0000_0000, 4'd1));
      send_item(key_item(CMD_LOOKUP, 64'h4143_0000_0000_0000, 4'd2));
      send_item(key_item(CMD_LOOKUP, ~64'd0, 4'd9));
      q = key_item(CMD_RANGE, 64'd0, 4'd0);
      q.upper_key_value = ~64'd0;
      q.upper_key_length = 4'd15;
      send_item(q);
      q = key_item(CMD_RANGE, 64'h4200_0000_0000_0000, 4'd1);
      q.upper_key_value = 64'h4100_0000_0000_0000;
      q.upper_key_length = 4'd1;
      send_item(q);
      send_item(key_item(CMD_FINALIZE, 64'd0, 4'd0));
      for (logic [2:0] c = 3'd5; c != 3'd0; c++) send_item(key_item(c, 64'd0, 4'd0));
      q = key_item(CMD_REMOVE, 64'd0, 4'd0);
      q.segment_number = '1;
      send_item(q);
      send_item(q);
      q.segment_number = '0;
      send_item(q);
   endtask

   // Fill past capacity so the full status shows up, then empty by segment.
   task automatic test_table_full();
      req_type q;
      for (int i = 0; i < DEPTH + 2; i++) begin
         q = rand_item(CMD_INSERT);
         q.segment_number = 32'(i % 2);
         send_item(q);
      end
      q = rand_item(CMD_RANGE);
      q.key_length = 4'd0;
      q.upper_key_value = ~64'd0;
      q.upper_key_length = 4'd8;
      send_item(q);
      q.command = CMD_REMOVE;
      q.segment_number = 32'd0;
      send_item(q);
      q.segment_number = 32'd1;
      send_item(q);
   endtask

   // Disabled index answers every command without touching the table.
   task automatic test_disabled();
      write_enable(1'b0);
      for (int c = 0; c < 8; c++) send_item(rand_item(3'(c)));
      write_enable(1'b1);
   endtask

   // One mix throughout: inserts most often, then lookups and ranges; remove now and then.
   task automatic test_random_mix();
      int r;
      for (int i = 0; i < 220; i++) begin
         stall_quiet = (i % 80) >= 60;
         r = $urandom_range(0, 99);
         if (r < 45) send_item(rand_item(CMD_INSERT));
         else if (r < 65) send_item(rand_item(CMD_LOOKUP));
         else if (r < 82) send_item(rand_item(CMD_RANGE));
         else if (r < 90) send_item(rand_item(CMD_REMOVE));
         else if (r < 96) send_item(rand_item(CMD_FINALIZE));
         else send_item(rand_item(3'($urandom_range(5, 7))));
      end
      stall_quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      stall_quiet = 1'b0;
      error_count = 0;
      tbl_count = 0;
      tbl_enabled = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_disabled();
      test_table_full();
      write_enable(1'b1);
      test_random_mix();
      test_disabled();
      drain_responses();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
